// File: sv/http_request_byte_parser_defines.svh
// ---------------------------------------------------------------------------
// HTTP request byte parser: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define HRBP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define HRBP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define HRBP_ASSERT(label, clk, rstn, prop)

`define HRBP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: sv/hrbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrbp_pkg
// Shared types, codes and helper functions of the HTTP request byte parser.
// ---------------------------------------------------------------------------
package hrbp_pkg;

    localparam int POSITION_WIDTH_DEFAULT     = 20;
    localparam int LENGTH_WIDTH_DEFAULT       = 31;
    localparam int HEADER_COUNT_WIDTH_DEFAULT = 8;

    localparam logic [7:0] KEEP_LIMIT_RESET = 8'd15;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_METHOD_LIMIT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERSION_LIMIT = 2'd1;

    localparam int PART_W = 3;
    localparam logic [PART_W-1:0] PART_IGNORED = 3'd0;
    localparam logic [PART_W-1:0] PART_METHOD  = 3'd1;
    localparam logic [PART_W-1:0] PART_PATH    = 3'd2;
    localparam logic [PART_W-1:0] PART_VERSION = 3'd3;
    localparam logic [PART_W-1:0] PART_NAME    = 3'd4;
    localparam logic [PART_W-1:0] PART_VALUE   = 3'd5;
    localparam logic [PART_W-1:0] PART_BODY    = 3'd6;
    localparam logic [PART_W-1:0] PART_DELIM   = 3'd7;

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_METHOD     = 4'd0;
    localparam logic [PH_W-1:0] PH_PATH       = 4'd1;
    localparam logic [PH_W-1:0] PH_VERSION    = 4'd2;
    localparam logic [PH_W-1:0] PH_LINE_START = 4'd3;
    localparam logic [PH_W-1:0] PH_NAME       = 4'd4;
    localparam logic [PH_W-1:0] PH_SKIP       = 4'd5;
    localparam logic [PH_W-1:0] PH_VALUE      = 4'd6;
    localparam logic [PH_W-1:0] PH_BODY       = 4'd7;
    localparam logic [PH_W-1:0] PH_COMPLETE   = 4'd8;

    localparam int NUM_W = 2;
    localparam logic [NUM_W-1:0] NUM_START   = 2'd0;
    localparam logic [NUM_W-1:0] NUM_DIGITS  = 2'd1;
    localparam logic [NUM_W-1:0] NUM_STOPPED = 2'd2;

    localparam int NAME_IDX_W = 4;
    localparam logic [NAME_IDX_W-1:0] NAME_LEN = 4'd14;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] data;
    } num_ctrl_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_HT) && (c <= CHAR_CR));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
    endfunction

    // lower-case "content-length"
    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/hrbp_number.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrbp_number
// Decimal value parser for a header value: optional sign, digits, saturation.
// ---------------------------------------------------------------------------
module hrbp_number #(
    parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hrbp_pkg::num_ctrl_t     ctrl,
    output logic [LENGTH_WIDTH-1:0] value
);

    localparam int SUM_W = LENGTH_WIDTH + 4;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    logic [hrbp_pkg::NUM_W-1:0] mode_reg, mode_next;
    logic                       neg_reg, neg_next;
    logic [LENGTH_WIDTH-1:0]    acc_reg, acc_next;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic [SUM_W-1:0]           sum;
    logic [LENGTH_WIDTH-1:0]    acc_step;

    assign is_digit = (ctrl.data >= hrbp_pkg::CHAR_ZERO) && (ctrl.data <= hrbp_pkg::CHAR_NINE);
    assign digit    = 4'(ctrl.data - hrbp_pkg::CHAR_ZERO);
    assign sum      = (SUM_W'(acc_reg) << 3) + (SUM_W'(acc_reg) << 1) + SUM_W'(digit);
    assign acc_step = (sum > SUM_W'(LEN_MAX)) ? LEN_MAX : sum[LENGTH_WIDTH-1:0];

    always_comb begin
        mode_next = mode_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        if (ctrl.clear) begin
            mode_next = hrbp_pkg::NUM_START;
            neg_next  = 1'b0;
            acc_next  = '0;
        end else if (ctrl.feed) begin
            unique case (mode_reg)
                hrbp_pkg::NUM_START: begin
                    if (hrbp_pkg::is_ws(ctrl.data)) begin
                        mode_next = mode_reg;
                    end else if (ctrl.data == hrbp_pkg::CHAR_PLUS) begin
                        mode_next = hrbp_pkg::NUM_DIGITS;
                    end else if (ctrl.data == hrbp_pkg::CHAR_MINUS) begin
                        mode_next = hrbp_pkg::NUM_DIGITS;
                        neg_next  = 1'b1;
                    end else if (is_digit) begin
                        mode_next = hrbp_pkg::NUM_DIGITS;
                        acc_next  = acc_step;
                    end else begin
                        mode_next = hrbp_pkg::NUM_STOPPED;
                    end
                end
                hrbp_pkg::NUM_DIGITS: begin
                    if (is_digit) begin
                        acc_next = acc_step;
                    end else begin
                        mode_next = hrbp_pkg::NUM_STOPPED;
                    end
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hrbp_pkg::NUM_START;
            neg_reg  <= 1'b0;
            acc_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            neg_reg  <= neg_next;
            acc_reg  <= acc_next;
        end
    end

    assign value = neg_reg ? '0 : acc_reg;

endmodule

// File: sv/http_request_byte_parser.sv
`timescale 1ns / 1ps
// Flow: an accepted byte is held in the input register and parsed into the output register,
// provided the output register is free or being read; otherwise it waits in the input register.
// Throughput: one byte per cycle while m_tready does not stall; the parser state updates once per byte.
// Reset: synchronous, active low; clears all parser state, empties both registers and
// returns both keep limits to 15.
// ---------------------------------------------------------------------------
// http_request_byte_parser
// Tags each byte of a raw HTTP request with its part, position and header
// number, and tracks Content-Length and the body countdown.
// ---------------------------------------------------------------------------
`include "http_request_byte_parser_defines.svh"

module http_request_byte_parser #(
    parameter int POSITION_WIDTH     = hrbp_pkg::POSITION_WIDTH_DEFAULT,
    parameter int LENGTH_WIDTH       = hrbp_pkg::LENGTH_WIDTH_DEFAULT,
    parameter int HEADER_COUNT_WIDTH = hrbp_pkg::HEADER_COUNT_WIDTH_DEFAULT,
    localparam int PAYLOAD_W = 8 + POSITION_WIDTH + HEADER_COUNT_WIDTH + 1 + LENGTH_WIDTH + 1,
    localparam int M_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [hrbp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                      cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    input  logic                            s_tlast,  // end_of_request
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // byte_echo, position, header_number, stored, body_length, request_complete
    output logic [M_DATA_W-1:0]             m_tdata,
    output logic [hrbp_pkg::PART_W-1:0]     m_tuser,  // part
    output logic                            m_tlast   // request_done
);

    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

    // configuration registers
    logic [7:0] method_limit_reg;
    logic [7:0] version_limit_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    logic [hrbp_pkg::PH_W-1:0]       ph_reg, ph_next;
    logic                            pend_reg, pend_next;
    logic [POSITION_WIDTH-1:0]       tok_reg, tok_next;
    logic [HEADER_COUNT_WIDTH-1:0]   hdr_reg, hdr_next;
    logic [hrbp_pkg::NAME_IDX_W-1:0] idx_reg, idx_next;
    logic                            still_reg, still_next;
    logic                            vil_reg, vil_next;
    logic [LENGTH_WIDTH-1:0]         cl_reg, cl_next;
    logic [LENGTH_WIDTH-1:0]         rem_reg, rem_next;

    // output register
    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic [hrbp_pkg::PART_W-1:0]   out_part_reg, out_part_next;
    logic [POSITION_WIDTH-1:0]     out_pos_reg, out_pos_next;
    logic [HEADER_COUNT_WIDTH-1:0] out_hdr_reg, out_hdr_next;
    logic                          out_stored_reg, out_stored_next;
    logic [LENGTH_WIDTH-1:0]       out_len_reg, out_len_next;
    logic                          out_done_reg;
    logic                          out_cmpl_reg, out_cmpl_next;

    logic                      advance;
    logic [7:0]                c;
    logic                      done;
    logic                      line_end;
    logic                      sep;
    logic                      name_hit;
    logic                      name_hit_first;
    logic [POSITION_WIDTH-1:0] tok_inc;
    logic [LENGTH_WIDTH-1:0]   rem_dec;
    logic [LENGTH_WIDTH-1:0]   num_value;
    hrbp_pkg::num_ctrl_t       num_ctrl;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign c        = in_byte_reg;
    assign done     = in_last_reg || (c == hrbp_pkg::CHAR_NUL);
    assign line_end = (c == hrbp_pkg::CHAR_CR) || (c == hrbp_pkg::CHAR_LF);
    assign sep      = (c == hrbp_pkg::CHAR_COLON) || hrbp_pkg::is_ws(c);
    assign tok_inc  = (&tok_reg) ? tok_reg : tok_reg + POS_ONE;
    assign rem_dec  = (rem_reg != '0) ? rem_reg - LENGTH_WIDTH'(1) : rem_reg;

    assign name_hit = still_reg && (idx_reg < hrbp_pkg::NAME_LEN) &&
                      (hrbp_pkg::to_lower(c) == hrbp_pkg::name_char(idx_reg));
    assign name_hit_first = hrbp_pkg::to_lower(c) == hrbp_pkg::name_char('0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_limit_reg  <= hrbp_pkg::KEEP_LIMIT_RESET;
            version_limit_reg <= hrbp_pkg::KEEP_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                hrbp_pkg::CFG_METHOD_LIMIT:  method_limit_reg  <= cfg_wdata;
                hrbp_pkg::CFG_VERSION_LIMIT: version_limit_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        ph_next    = ph_reg;
        pend_next  = pend_reg;
        tok_next   = tok_reg;
        hdr_next   = hdr_reg;
        idx_next   = idx_reg;
        still_next = still_reg;
        vil_next   = vil_reg;
        cl_next    = cl_reg;
        rem_next   = rem_reg;

        out_part_next   = hrbp_pkg::PART_IGNORED;
        out_pos_next    = '0;
        out_stored_next = 1'b0;

        num_ctrl.clear = 1'b0;
        num_ctrl.feed  = 1'b0;
        num_ctrl.data  = c;

        if (c != hrbp_pkg::CHAR_NUL && pend_reg && c == hrbp_pkg::CHAR_LF) begin
            pend_next     = 1'b0;
            out_part_next = hrbp_pkg::PART_DELIM;
        end else if (c != hrbp_pkg::CHAR_NUL) begin
            pend_next = 1'b0;
            unique case (ph_reg)
                hrbp_pkg::PH_METHOD: begin
                    if (hrbp_pkg::is_ws(c)) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        ph_next       = hrbp_pkg::PH_PATH;
                        tok_next      = '0;
                    end else begin
                        out_part_next   = hrbp_pkg::PART_METHOD;
                        out_pos_next    = tok_reg;
                        out_stored_next = tok_reg < POSITION_WIDTH'(method_limit_reg);
                        tok_next        = tok_inc;
                    end
                end
                hrbp_pkg::PH_PATH: begin
                    if (hrbp_pkg::is_ws(c)) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        ph_next       = hrbp_pkg::PH_VERSION;
                        tok_next      = '0;
                    end else begin
                        out_part_next   = hrbp_pkg::PART_PATH;
                        out_pos_next    = tok_reg;
                        out_stored_next = 1'b1;
                        tok_next        = tok_inc;
                    end
                end
                hrbp_pkg::PH_VERSION: begin
                    if (line_end) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        pend_next     = c == hrbp_pkg::CHAR_CR;
                        ph_next       = hrbp_pkg::PH_LINE_START;
                    end else begin
                        out_part_next   = hrbp_pkg::PART_VERSION;
                        out_pos_next    = tok_reg;
                        out_stored_next = tok_reg < POSITION_WIDTH'(version_limit_reg);
                        tok_next        = tok_inc;
                    end
                end
                hrbp_pkg::PH_LINE_START: begin
                    if (line_end) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        pend_next     = c == hrbp_pkg::CHAR_CR;
                        if (cl_reg != '0) begin
                            ph_next  = hrbp_pkg::PH_BODY;
                            rem_next = cl_reg;
                            tok_next = '0;
                        end else begin
                            ph_next = hrbp_pkg::PH_COMPLETE;
                        end
                    end else begin
                        hdr_next       = (&hdr_reg) ? hdr_reg
                                                    : hdr_reg + HEADER_COUNT_WIDTH'(1);
                        idx_next       = '0;
                        still_next     = 1'b1;
                        vil_next       = 1'b0;
                        num_ctrl.clear = 1'b1;
                        tok_next       = '0;
                        if (sep) begin
                            out_part_next = hrbp_pkg::PART_DELIM;
                            ph_next       = hrbp_pkg::PH_SKIP;
                        end else begin
                            out_part_next   = hrbp_pkg::PART_NAME;
                            out_stored_next = 1'b1;
                            tok_next        = POS_ONE;
                            ph_next         = hrbp_pkg::PH_NAME;
                            if (name_hit_first) begin
                                idx_next = hrbp_pkg::NAME_IDX_W'(1);
                            end else begin
                                still_next = 1'b0;
                            end
                        end
                    end
                end
                hrbp_pkg::PH_NAME: begin
                    if (sep) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        vil_next      = still_reg && (idx_reg == hrbp_pkg::NAME_LEN);
                        ph_next       = hrbp_pkg::PH_SKIP;
                    end else begin
                        out_part_next   = hrbp_pkg::PART_NAME;
                        out_pos_next    = tok_reg;
                        out_stored_next = 1'b1;
                        tok_next        = tok_inc;
                        if (name_hit) begin
                            idx_next = idx_reg + hrbp_pkg::NAME_IDX_W'(1);
                        end else begin
                            still_next = 1'b0;
                        end
                    end
                end
                hrbp_pkg::PH_SKIP: begin
                    if (sep) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                    end else begin
                        out_part_next   = hrbp_pkg::PART_VALUE;
                        out_stored_next = 1'b1;
                        tok_next        = POS_ONE;
                        ph_next         = hrbp_pkg::PH_VALUE;
                        num_ctrl.feed   = 1'b1;
                    end
                end
                hrbp_pkg::PH_VALUE: begin
                    if (line_end) begin
                        out_part_next = hrbp_pkg::PART_DELIM;
                        pend_next     = c == hrbp_pkg::CHAR_CR;
                        ph_next       = hrbp_pkg::PH_LINE_START;
                        if (vil_reg) begin
                            cl_next = num_value;
                        end
                    end else begin
                        out_part_next   = hrbp_pkg::PART_VALUE;
                        out_pos_next    = tok_reg;
                        out_stored_next = 1'b1;
                        tok_next        = tok_inc;
                        num_ctrl.feed   = 1'b1;
                    end
                end
                hrbp_pkg::PH_BODY: begin
                    out_part_next   = hrbp_pkg::PART_BODY;
                    out_pos_next    = tok_reg;
                    out_stored_next = 1'b1;
                    tok_next        = tok_inc;
                    rem_next        = rem_dec;
                    if (rem_dec == '0) begin
                        ph_next = hrbp_pkg::PH_COMPLETE;
                    end
                end
                default: begin
                    out_part_next = hrbp_pkg::PART_IGNORED;
                end
            endcase
        end

        out_hdr_next  = hdr_next;
        out_len_next  = cl_next;
        out_cmpl_next = ph_next == hrbp_pkg::PH_COMPLETE;

        // start over for the next request
        if (done) begin
            ph_next        = hrbp_pkg::PH_METHOD;
            pend_next      = 1'b0;
            tok_next       = '0;
            hdr_next       = '0;
            idx_next       = '0;
            still_next     = 1'b1;
            vil_next       = 1'b0;
            cl_next        = '0;
            rem_next       = '0;
            num_ctrl.clear = 1'b1;
        end

        if (!advance) begin
            num_ctrl.clear = 1'b0;
            num_ctrl.feed  = 1'b0;
        end
    end

    hrbp_number #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_number (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (num_ctrl),
        .value   (num_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= hrbp_pkg::PH_METHOD;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
            hdr_reg   <= '0;
            idx_reg   <= '0;
            still_reg <= 1'b1;
            vil_reg   <= 1'b0;
            cl_reg    <= '0;
            rem_reg   <= '0;
        end else if (advance) begin
            ph_reg    <= ph_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
            hdr_reg   <= hdr_next;
            idx_reg   <= idx_next;
            still_reg <= still_next;
            vil_reg   <= vil_next;
            cl_reg    <= cl_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg   <= c;
            out_part_reg   <= out_part_next;
            out_pos_reg    <= out_pos_next;
            out_hdr_reg    <= out_hdr_next;
            out_stored_reg <= out_stored_next;
            out_len_reg    <= out_len_next;
            out_done_reg   <= done;
            out_cmpl_reg   <= out_cmpl_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_part_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = M_DATA_W'({out_cmpl_reg, out_len_reg, out_stored_reg,
                                 out_hdr_reg, out_pos_reg, out_byte_reg});

    `HRBP_ASSERT(a_clear_after_done, aclk, aresetn,
        (advance && done) |=> (ph_reg == hrbp_pkg::PH_METHOD && hdr_reg == '0 && cl_reg == '0))
    `HRBP_ASSERT(a_body_countdown, aclk, aresetn,
        (ph_reg == hrbp_pkg::PH_BODY) |-> (rem_reg != '0 && rem_reg <= cl_reg))
    `HRBP_ASSERT(a_pending_lf_phase, aclk, aresetn,
        pend_reg |-> (ph_reg == hrbp_pkg::PH_LINE_START || ph_reg == hrbp_pkg::PH_BODY ||
                      ph_reg == hrbp_pkg::PH_COMPLETE))
    `HRBP_ASSERT(a_body_tag_source, aclk, aresetn,
        (advance && out_part_next == hrbp_pkg::PART_BODY) |-> (ph_reg == hrbp_pkg::PH_BODY))
    `HRBP_ASSERT_ALWAYS(a_reset_empties, aclk,
        !aresetn |=> (!m_tvalid && s_tready))

endmodule
